@@ rtl/core/tpsd_pkg.sv @@
// Package for the TGA pixel stream decoder: status and register codes,
// decoder constants and the result record type. No dependencies.
`timescale 1ns / 1ps

package tpsd_pkg;

  // Status codes carried on each result
  localparam logic [2:0] ST_RUNNING   = 3'd0;
  localparam logic [2:0] ST_COMPLETE  = 3'd1;
  localparam logic [2:0] ST_EARLY_END = 3'd2;
  localparam logic [2:0] ST_OVERRUN   = 3'd3;
  localparam logic [2:0] ST_TRUNCATED = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RLE_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 2'd2;

  // Register reset values
  localparam logic        RLE_MODE_RST    = 1'b1;
  localparam logic [2:0]  BPP_RST         = 3'd4;
  localparam logic [31:0] PIXEL_COUNT_RST = 32'd1;

  // Packet header split and derived constants
  localparam logic [7:0]  HDR_RUN_BIT     = 8'd128;
  localparam logic [7:0]  HDR_RUN_BIAS    = 8'd127;
  localparam logic [7:0]  ALPHA_OPAQUE    = 8'd255;
  localparam logic [2:0]  BPP_BGR         = 3'd3;
  localparam logic [31:0] PIXEL_BYTES_RST = 32'hFF00_0000;

  // One result request
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_res;
    logic [2:0] status;
  } res_t;

endpackage

@@ rtl/core/tga_pixel_stream_decoder.sv @@
// Each result is registered in the output register or the skid register behind it.
// Throughput: one byte per cycle while the skid register is empty; the decoder state
// updates in a single pass per byte, and a two-entry output buffer (output plus skid
// register) keeps input open while one result waits. Reset (rst_n, synchronous): config
// registers to defaults, decoder restarted, output buffer emptied. Any register write
// restarts decoding. Top level of the TGA pixel stream decoder; uses tpsd_pkg.
`timescale 1ns / 1ps

module tga_pixel_stream_decoder
  import tpsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Input byte channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_stream_end,
  // Result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  output logic [7:0]           out_alpha,
  output logic [7:0]           out_repeat_res,
  output logic [2:0]           out_status,
  // Configuration write port
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wr_data
);

  // Configuration registers
  logic        rle_mode_r;
  logic [2:0]  bpp_r;
  logic [31:0] pixel_count_r;

  // Decoder state
  logic [31:0] pixels_left_r, pixels_left_nxt;
  logic [7:0]  packet_left_r, packet_left_nxt;
  logic        packet_is_run_r, packet_is_run_nxt;
  logic [1:0]  byte_in_pixel_r, byte_in_pixel_nxt;
  logic [31:0] pixel_bytes_r, pixel_bytes_nxt;
  logic        finished_r, finished_nxt;

  // Output buffer
  res_t out_r, out_nxt, skid_r, skid_nxt;
  logic out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;

  logic       in_fire, cfg_hit, bpp_is_bgr, produced, push;
  logic [1:0] bip_inc, last_idx;
  logic [2:0] status;
  logic [7:0] rep;
  res_t       res;

  assign in_ready   = !skid_valid_r;
  assign in_fire    = in_valid && in_ready;
  assign cfg_hit    = cfg_wr_en && (cfg_index == REG_RLE_MODE || cfg_index == REG_BYTES_PER_PX ||
                                    cfg_index == REG_PIXEL_COUNT);
  assign bpp_is_bgr = (bpp_r == BPP_BGR);
  assign last_idx   = bpp_is_bgr ? 2'd3 : 2'd0;
  assign bip_inc    = byte_in_pixel_r + 2'd1;

  // Decode one byte: header parse, pixel assembly, counters and status
  always_comb begin
    pixels_left_nxt   = pixels_left_r;
    packet_left_nxt   = packet_left_r;
    packet_is_run_nxt = packet_is_run_r;
    byte_in_pixel_nxt = byte_in_pixel_r;
    pixel_bytes_nxt   = pixel_bytes_r;
    finished_nxt      = finished_r;
    produced          = 1'b0;
    rep               = 8'd0;
    status            = ST_RUNNING;
    push              = 1'b0;
    if (in_fire && !finished_r) begin
      if (pixels_left_r == 32'd0) begin
        finished_nxt = 1'b1;
        status       = ST_COMPLETE;
        push         = 1'b1;
      end else begin
        if (rle_mode_r && packet_left_r == 8'd0) begin
          // packet header
          if (in_data_byte < HDR_RUN_BIT) begin
            packet_is_run_nxt = 1'b0;
            packet_left_nxt   = in_data_byte + 8'd1;
          end else begin
            packet_is_run_nxt = 1'b1;
            packet_left_nxt   = in_data_byte - HDR_RUN_BIAS;
          end
          byte_in_pixel_nxt = 2'd0;
        end else begin
          // pixel byte
          pixel_bytes_nxt[{byte_in_pixel_r, 3'b000} +: 8] = in_data_byte;
          if (bip_inc == last_idx) begin
            byte_in_pixel_nxt = 2'd0;
            produced          = 1'b1;
            if (!rle_mode_r) begin
              rep             = 8'd1;
              pixels_left_nxt = pixels_left_r - 32'd1;
              if (pixels_left_nxt == 32'd0) begin
                status = ST_COMPLETE;
              end
            end else if (packet_is_run_r) begin
              packet_left_nxt = 8'd0;
              if ({24'd0, packet_left_r} <= pixels_left_r) begin
                rep             = packet_left_r;
                pixels_left_nxt = pixels_left_r - {24'd0, packet_left_r};
                if (pixels_left_nxt == 32'd0) begin
                  status = ST_COMPLETE;
                end
              end else begin
                // run overruns the image: fewer than 128 pixels remain here
                rep             = pixels_left_r[7:0];
                pixels_left_nxt = 32'd0;
                status          = ST_OVERRUN;
              end
            end else begin
              rep             = 8'd1;
              packet_left_nxt = packet_left_r - 8'd1;
              pixels_left_nxt = pixels_left_r - 32'd1;
              if (pixels_left_nxt == 32'd0) begin
                status = (packet_left_nxt == 8'd0) ? ST_COMPLETE : ST_OVERRUN;
              end
            end
          end else begin
            byte_in_pixel_nxt = bip_inc;
          end
        end
        // finish on a final status or on the end marker
        if (status != ST_RUNNING) begin
          finished_nxt = 1'b1;
        end else if (in_stream_end) begin
          finished_nxt = 1'b1;
          if (rle_mode_r && packet_left_nxt == 8'd0 && byte_in_pixel_nxt == 2'd0) begin
            status = ST_EARLY_END;
          end else begin
            status = ST_TRUNCATED;
          end
        end
        push = produced || (status != ST_RUNNING);
      end
    end
  end

  // Build the result request
  always_comb begin
    res = '0;
    res.status = status;
    if (produced) begin
      res.red        = pixel_bytes_nxt[23:16];
      res.green      = pixel_bytes_nxt[15:8];
      res.blue       = pixel_bytes_nxt[7:0];
      res.alpha      = bpp_is_bgr ? ALPHA_OPAQUE : pixel_bytes_nxt[31:24];
      res.repeat_res = rep;
    end
  end

  // Advance the output register and skid register
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_valid_r && out_ready) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (push && !cfg_wr_en) begin
      if (!out_valid_nxt) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rle_mode_r    <= RLE_MODE_RST;
      bpp_r         <= BPP_RST;
      pixel_count_r <= PIXEL_COUNT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RLE_MODE:     rle_mode_r    <= cfg_wr_data[0];
        REG_BYTES_PER_PX: bpp_r         <= cfg_wr_data[2:0];
        REG_PIXEL_COUNT:  pixel_count_r <= cfg_wr_data;
        default:          ;
      endcase
    end
  end

  // Decoder state; restart on reset or on any register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixels_left_r   <= PIXEL_COUNT_RST;
      packet_left_r   <= 8'd0;
      packet_is_run_r <= 1'b0;
      byte_in_pixel_r <= 2'd0;
      pixel_bytes_r   <= PIXEL_BYTES_RST;
      finished_r      <= 1'b0;
    end else if (cfg_hit) begin
      pixels_left_r   <= (cfg_index == REG_PIXEL_COUNT) ? cfg_wr_data : pixel_count_r;
      packet_left_r   <= 8'd0;
      packet_is_run_r <= 1'b0;
      byte_in_pixel_r <= 2'd0;
      pixel_bytes_r   <= PIXEL_BYTES_RST;
      finished_r      <= 1'b0;
    end else if (!cfg_wr_en) begin
      pixels_left_r   <= pixels_left_nxt;
      packet_left_r   <= packet_left_nxt;
      packet_is_run_r <= packet_is_run_nxt;
      byte_in_pixel_r <= byte_in_pixel_nxt;
      pixel_bytes_r   <= pixel_bytes_nxt;
      finished_r      <= finished_nxt;
    end
  end

  // Output buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Output buffer payload
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_r.red;
  assign out_green      = out_r.green;
  assign out_blue       = out_r.blue;
  assign out_alpha      = out_r.alpha;
  assign out_repeat_res = out_r.repeat_res;
  assign out_status     = out_r.status;

  // Skid register only fills behind a held output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a request while output register is empty");

  // A status-only result always carries a final status
  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.repeat_res == 8'd0 |-> out_r.status != ST_RUNNING)
    else $error("empty result with running status");

  // Repeat count never exceeds the longest run
  a_repeat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.repeat_res <= HDR_RUN_BIT)
    else $error("repeat count out of range");

  // Once finished, only a register write restarts decoding
  a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r && !cfg_wr_en |=> finished_r)
    else $error("decoder left the finished state without a restart");

  // A finished decoder emits nothing further
  a_no_push_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> !push)
    else $error("result produced after decoding finished");

endmodule
